[src/scpd_pkg.sv]
// Shared constants and types for the segment clipper.
package scpd_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic fault;
		logic neg_a;
		logic neg_b;
	} flags_t;

endpackage

[src/scpd_front.sv]
// Front end: accepts a transaction, forms coordinate differences and classifies the divisor.
module scpd_front #(
	parameter int W = scpd_pkg::COORD_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [W-1:0]  seg_start_x,
	input  logic signed [W-1:0]  seg_start_y,
	input  logic signed [W-1:0]  seg_end_x,
	input  logic signed [W-1:0]  seg_end_y,
	input  logic signed [W-1:0]  point_x,
	input  logic signed [W-1:0]  point_y,
	input  logic                 full,
	output logic                 push,
	output logic [6*W-1:0]       coords,
	output logic [4*W+3:0]       mags,
	output scpd_pkg::flags_t     flags
);

	logic signed [W:0] da, db, dc, dd;
	logic [W:0] ma, mb, mc, md;
	logic accept;
	logic valid_s1;
	logic [6*W-1:0] coords_s1;
	logic [4*W+3:0] mags_s1;
	scpd_pkg::flags_t flags_s1;
	scpd_pkg::flags_t flags_c;

	assign da = {point_x[W-1], point_x} - {seg_start_x[W-1], seg_start_x};
	assign db = {seg_end_y[W-1], seg_end_y} - {seg_start_y[W-1], seg_start_y};
	assign dc = {seg_end_x[W-1], seg_end_x} - {seg_start_x[W-1], seg_start_x};
	assign dd = {point_y[W-1], point_y} - {seg_start_y[W-1], seg_start_y};

	assign ma = da[W] ? -da : da;
	assign mb = db[W] ? -db : db;
	assign mc = dc[W] ? -dc : dc;
	assign md = dd[W] ? -dd : dd;

	always_comb begin
		flags_c.fault = (dc == '0) || (db == '0);
		flags_c.neg_a = da[W] ^ db[W] ^ dc[W];
		flags_c.neg_b = dd[W] ^ dc[W] ^ db[W];
	end

	assign busy = valid_s1 && full;
	assign accept = start && !busy;
	assign push = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coords_s1 <= {seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y};
			mags_s1 <= {ma, mb, mc, md};
			flags_s1 <= flags_c;
		end
	end

	assign coords = coords_s1;
	assign mags = mags_s1;
	assign flags = flags_s1;

endmodule

[src/scpd_fifo.sv]
// Short queue that decouples the front end from the arithmetic back end.
module scpd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = scpd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign pop = valid;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

[src/scpd_interp.sv]
// Pipelined interpolation base +/- floor(a*b/d) with saturation, one quotient bit per stage.
module scpd_interp #(
	parameter int W = scpd_pkg::COORD_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W-1:0] base,
	input  logic [W:0]          an,
	input  logic [W:0]          am,
	input  logic [W:0]          ad,
	input  logic                neg,
	output logic                out_valid,
	output logic signed [W-1:0] res
);

	localparam int MW = W + 1;
	localparam int H = (MW + 1) / 2;
	localparam int PW = 2 * MW;
	localparam logic [W+2:0] SMAX = {4'b0000, {(W-1){1'b1}}};
	localparam logic [W+2:0] SMIN = {4'b1111, {(W-1){1'b0}}};
	localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	logic v_s1;
	logic [MW+H-1:0] pl_s1;
	logic [2*MW-H-1:0] ph_s1;
	logic [MW-1:0] ad_s1;
	logic signed [W-1:0] base_s1;
	logic neg_s1;
	logic [PW-1:0] prod;

	logic v_q [MW+1];
	logic [MW-1:0] rem_q [MW+1];
	logic [MW-1:0] lo_q [MW+1];
	logic [MW-1:0] quo_q [MW+1];
	logic [MW-1:0] ad_q [MW+1];
	logic signed [W-1:0] base_q [MW+1];
	logic neg_q [MW+1];
	logic ovf_q [MW+1];

	logic signed [W+2:0] bext, mext, sum;
	logic out_v_q;
	logic signed [W-1:0] res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q[0] <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_q[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pl_s1 <= an * am[H-1:0];
		ph_s1 <= an * am[MW-1:H];
		ad_s1 <= ad;
		base_s1 <= base;
		neg_s1 <= neg;
	end

	assign prod = PW'(pl_s1) + (PW'(ph_s1) << H);

	always_ff @(posedge clk) begin
		rem_q[0] <= prod[PW-1:MW];
		lo_q[0] <= prod[MW-1:0];
		quo_q[0] <= '0;
		ad_q[0] <= ad_s1;
		base_q[0] <= base_s1;
		neg_q[0] <= neg_s1;
		ovf_q[0] <= 1'b0;
	end

	for (genvar k = 0; k < MW; k++) begin : g_div
		logic [MW:0] t;
		logic [MW:0] diff;
		logic ge;

		assign t = {rem_q[k], lo_q[k][MW-1]};
		assign diff = t - {1'b0, ad_q[k]};
		assign ge = (t >= {1'b0, ad_q[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k+1] <= ge ? diff[MW-1:0] : t[MW-1:0];
			lo_q[k+1] <= lo_q[k] << 1;
			quo_q[k+1] <= {quo_q[k][MW-2:0], ge};
			ad_q[k+1] <= ad_q[k];
			base_q[k+1] <= base_q[k];
			neg_q[k+1] <= neg_q[k];
			ovf_q[k+1] <= ovf_q[k] || (rem_q[k] >= ad_q[k]);
		end
	end

	assign bext = (W+3)'(base_q[MW]);
	assign mext = $signed({2'b00, quo_q[MW]});
	assign sum = neg_q[MW] ? bext - mext : bext + mext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= v_q[MW];
		end
	end

	always_ff @(posedge clk) begin
		if (ovf_q[MW]) begin
			res_q <= neg_q[MW] ? CMIN : CMAX;
		end else if (sum > $signed(SMAX)) begin
			res_q <= CMAX;
		end else if (sum < $signed(SMIN)) begin
			res_q <= CMIN;
		end else begin
			res_q <= sum[W-1:0];
		end
	end

	assign out_valid = out_v_q;
	assign res = res_q;

endmodule

[src/scpd_back.sv]
// Back end: computes pA and pB, applies the clipping rules and registers the result.
module scpd_back #(
	parameter int W = scpd_pkg::COORD_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [6*W-1:0]      coords,
	input  logic [4*W+3:0]      mags,
	input  scpd_pkg::flags_t    flags,
	output logic                done,
	output logic [1:0]          fragment_count,
	output logic signed [W-1:0] first_x0,
	output logic signed [W-1:0] first_y0,
	output logic signed [W-1:0] first_x1,
	output logic signed [W-1:0] first_y1,
	output logic signed [W-1:0] second_x0,
	output logic signed [W-1:0] second_y0,
	output logic signed [W-1:0] second_x1,
	output logic signed [W-1:0] second_y1,
	output logic                divide_fault
);

	localparam int LAT = W + 4;
	localparam int CXW = 6 * W + 1;

	logic [W:0] ma, mb, mc, md;
	logic signed [W-1:0] isx, isy;
	logic va, vb;
	logic signed [W-1:0] ya, xb;
	logic [CXW-1:0] ctx_q [LAT];

	logic signed [W-1:0] sx, sy, ex, ey, px, py;
	logic fault;
	logic signed [W-1:0] lx, ly, rx, ry;
	logic [1:0] n;
	logic signed [W-1:0] f0 [4];
	logic signed [W-1:0] f1 [4];
	logic done_q;
	logic [1:0] cnt_q;
	logic fault_q;
	logic signed [W-1:0] f0_q [4];
	logic signed [W-1:0] f1_q [4];

	assign {ma, mb, mc, md} = mags;
	assign isx = coords[6*W-1:5*W];
	assign isy = coords[5*W-1:4*W];

	scpd_interp #(.W(W)) u_ya (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .base(isy),
		.an(ma), .am(mb), .ad(mc), .neg(flags.neg_a), .out_valid(va), .res(ya)
	);

	scpd_interp #(.W(W)) u_xb (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .base(isx),
		.an(md), .am(mc), .ad(mb), .neg(flags.neg_b), .out_valid(vb), .res(xb)
	);

	always_ff @(posedge clk) begin
		ctx_q[0] <= {coords, flags.fault};
	end

	for (genvar k = 1; k < LAT; k++) begin : g_ctx
		always_ff @(posedge clk) begin
			ctx_q[k] <= ctx_q[k-1];
		end
	end

	assign {sx, sy, ex, ey, px, py, fault} = ctx_q[LAT-1];

	always_comb begin
		if (sx < ex) begin
			lx = sx; ly = sy; rx = ex; ry = ey;
		end else begin
			lx = ex; ly = ey; rx = sx; ry = sy;
		end
		n = 2'd0;
		for (int i = 0; i < 4; i++) begin
			f0[i] = '0;
			f1[i] = '0;
		end
		if (fault) begin
			n = 2'd0;
		end else if (ly > ry) begin
			if (py > ya || (lx > px && lx > xb) || (rx < px && rx < xb)) begin
				f0[0] = sx; f0[1] = sy; f0[2] = ex; f0[3] = ey;
				n = 2'd1;
			end else if (lx >= px && rx <= xb) begin
				n = 2'd0;
			end else if (lx < px && rx > xb) begin
				f0[0] = lx; f0[1] = ly; f0[2] = px; f0[3] = ya;
				f1[0] = xb; f1[1] = py; f1[2] = rx; f1[3] = ry;
				n = 2'd2;
			end else if (lx > px && rx > xb) begin
				f0[0] = xb; f0[1] = py; f0[2] = rx; f0[3] = ry;
				n = 2'd1;
			end else if (lx < px && rx < xb) begin
				f0[0] = lx; f0[1] = ly; f0[2] = px; f0[3] = ya;
				n = 2'd1;
			end
		end else begin
			if ((py > ya && rx < xb) || rx < px) begin
				f0[0] = sx; f0[1] = sy; f0[2] = ex; f0[3] = ey;
				n = 2'd1;
			end else if (lx < xb && rx > xb && ya < py) begin
				f0[0] = lx; f0[1] = ly; f0[2] = xb; f0[3] = py;
				n = 2'd1;
			end else if (lx < px && rx > px && ya > py) begin
				f0[0] = lx; f0[1] = ly; f0[2] = px; f0[3] = ya;
				n = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= va && vb;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= n;
		fault_q <= fault;
		f0_q <= f0;
		f1_q <= f1;
	end

	assign done = done_q;
	assign fragment_count = cnt_q;
	assign divide_fault = fault_q;
	assign first_x0 = f0_q[0];
	assign first_y0 = f0_q[1];
	assign first_x1 = f0_q[2];
	assign first_y1 = f0_q[3];
	assign second_x0 = f1_q[0];
	assign second_y0 = f1_q[1];
	assign second_x1 = f1_q[2];
	assign second_y1 = f1_q[3];

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n) va == vb)
		else $error("interpolation lanes out of step");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fragment_count != 2'd3)
		else $error("fragment count out of range");
	a_fault_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_fault |-> fragment_count == 2'd0)
		else $error("fragments reported with a zero divisor");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(in_valid, LAT + 1))
		else $error("result without a matching transaction");

endmodule

[src/segment_clip_by_point_dominance.sv]
// Top level of the segment clipper: front end, queue and arithmetic back end.
// Throughput: one transaction per cycle while busy is low, set by the fully pipelined multiply and
// one-quotient-bit-per-stage divide in the back end.
// The result is shown for exactly one cycle with done; the receiver cannot stall.
// Reset clears all valid and queue state asynchronously; data registers are not reset.
module segment_clip_by_point_dominance #(
	parameter int COORD_WIDTH = scpd_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] seg_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_end_y,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          done,
	output logic [1:0]                    fragment_count,
	output logic signed [COORD_WIDTH-1:0] first_x0,
	output logic signed [COORD_WIDTH-1:0] first_y0,
	output logic signed [COORD_WIDTH-1:0] first_x1,
	output logic signed [COORD_WIDTH-1:0] first_y1,
	output logic signed [COORD_WIDTH-1:0] second_x0,
	output logic signed [COORD_WIDTH-1:0] second_y0,
	output logic signed [COORD_WIDTH-1:0] second_x1,
	output logic signed [COORD_WIDTH-1:0] second_y1,
	output logic                          divide_fault
);

	localparam int W = COORD_WIDTH;
	localparam int FW = $bits(scpd_pkg::flags_t);
	localparam int IW = 6 * W + 4 * (W + 1) + FW;

	logic full, push, q_valid;
	logic [6*W-1:0] f_coords, b_coords;
	logic [4*W+3:0] f_mags, b_mags;
	scpd_pkg::flags_t f_flags, b_flags;
	logic [IW-1:0] q_wdata, q_rdata;

	scpd_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
		.point_x(point_x), .point_y(point_y),
		.full(full), .push(push), .coords(f_coords), .mags(f_mags), .flags(f_flags)
	);

	assign q_wdata = {f_coords, f_mags, f_flags};

	scpd_fifo #(.WIDTH(IW), .DEPTH(scpd_pkg::QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(q_wdata),
		.full(full), .valid(q_valid), .rdata(q_rdata)
	);

	assign {b_coords, b_mags, b_flags} = q_rdata;

	scpd_back #(.W(W)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid),
		.coords(b_coords), .mags(b_mags), .flags(b_flags),
		.done(done), .fragment_count(fragment_count),
		.first_x0(first_x0), .first_y0(first_y0),
		.first_x1(first_x1), .first_y1(first_y1),
		.second_x0(second_x0), .second_y0(second_y0),
		.second_x1(second_x1), .second_y1(second_y1),
		.divide_fault(divide_fault)
	);

endmodule

[tb/segment_clip_by_point_dominance_chk.sv]
// Checker for the segment clipper: predicts each transaction's fragments and compares them.
`timescale 1ns / 1ps
module segment_clip_by_point_dominance_chk (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic                                    busy,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] seg_start_x,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] seg_start_y,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] seg_end_x,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] seg_end_y,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] point_x,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] point_y,
	input  logic                                    done,
	input  logic [1:0]                              fragment_count,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] first_x0,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] first_y0,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] first_x1,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] first_y1,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] second_x0,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] second_y0,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] second_x1,
	input  logic signed [scpd_pkg::COORD_WIDTH-1:0] second_y1,
	input  logic                                    divide_fault,
	output int                                      fail_count,
	output int                                      pending
);

	typedef logic signed [scpd_pkg::COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [1:0] count;
		coord_t     ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		logic       fault;
	} clip_t;

	clip_t expected_clips[$];

	localparam logic signed [127:0] CMAX = (128'sd1 <<< (scpd_pkg::COORD_WIDTH - 1)) - 1;
	localparam logic signed [127:0] CMIN = -CMAX - 1;

	function automatic coord_t lerp(coord_t base, coord_t n1, coord_t n0,
			coord_t m1, coord_t m0, coord_t d1, coord_t d0);
		logic signed [127:0] num, den, q, s;
		num = (128'(n1) - 128'(n0)) * (128'(m1) - 128'(m0));
		den = 128'(d1) - 128'(d0);
		q = num / den;
		s = 128'(base) + q;
		if (s > CMAX) s = CMAX;
		if (s < CMIN) s = CMIN;
		return coord_t'(s);
	endfunction

	function automatic clip_t clip_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			coord_t px, coord_t py);
		clip_t r;
		coord_t lx, ly, rx, ry, ya, xb;
		r = '0;
		if (ex == sx || ey == sy) begin
			r.fault = 1'b1;
			return r;
		end
		ya = lerp(sy, px, sx, ey, sy, ex, sx);
		xb = lerp(sx, py, sy, ex, sx, ey, sy);
		if (sx < ex) begin
			lx = sx; ly = sy; rx = ex; ry = ey;
		end else begin
			lx = ex; ly = ey; rx = sx; ry = sy;
		end
		if (ly > ry) begin
			if (py > ya || (lx > px && lx > xb) || (rx < px && rx < xb)) begin
				r.count = 2'd1; {r.ax0, r.ay0, r.ax1, r.ay1} = {sx, sy, ex, ey};
			end else if (lx >= px && rx <= xb) begin
				r.count = 2'd0;
			end else if (lx < px && rx > xb) begin
				r.count = 2'd2; {r.ax0, r.ay0, r.ax1, r.ay1} = {lx, ly, px, ya};
				{r.bx0, r.by0, r.bx1, r.by1} = {xb, py, rx, ry};
			end else if (lx > px && rx > xb) begin
				r.count = 2'd1; {r.ax0, r.ay0, r.ax1, r.ay1} = {xb, py, rx, ry};
			end else if (lx < px && rx < xb) begin
				r.count = 2'd1; {r.ax0, r.ay0, r.ax1, r.ay1} = {lx, ly, px, ya};
			end
		end else begin
			if ((py > ya && rx < xb) || rx < px) begin
				r.count = 2'd1; {r.ax0, r.ay0, r.ax1, r.ay1} = {sx, sy, ex, ey};
			end else if (lx < xb && rx > xb && ya < py) begin
				r.count = 2'd1; {r.ax0, r.ay0, r.ax1, r.ay1} = {lx, ly, xb, py};
			end else if (lx < px && rx > px && ya > py) begin
				r.count = 2'd1; {r.ax0, r.ay0, r.ax1, r.ay1} = {lx, ly, px, ya};
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic compare_clip(clip_t got);
		clip_t want;
		if (expected_clips.size() == 0) begin
			$display("%0t: result strobe with no transaction outstanding", $time);
			fail_count++;
			return;
		end
		want = expected_clips.pop_front();
		if (got.count !== want.count) report_mismatch("fragment_count", got.count, want.count);
		if (got.fault !== want.fault) report_mismatch("divide_fault", got.fault, want.fault);
		if (got.ax0 !== want.ax0) report_mismatch("first_x0", got.ax0, want.ax0);
		if (got.ay0 !== want.ay0) report_mismatch("first_y0", got.ay0, want.ay0);
		if (got.ax1 !== want.ax1) report_mismatch("first_x1", got.ax1, want.ax1);
		if (got.ay1 !== want.ay1) report_mismatch("first_y1", got.ay1, want.ay1);
		if (got.bx0 !== want.bx0) report_mismatch("second_x0", got.bx0, want.bx0);
		if (got.by0 !== want.by0) report_mismatch("second_y0", got.by0, want.by0);
		if (got.bx1 !== want.bx1) report_mismatch("second_x1", got.bx1, want.bx1);
		if (got.by1 !== want.by1) report_mismatch("second_y1", got.by1, want.by1);
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				compare_clip({fragment_count, first_x0, first_y0, first_x1, first_y1,
					second_x0, second_y0, second_x1, second_y1, divide_fault});
			else if (done !== 1'b0) begin
				$display("%0t: done strobe is unknown", $time);
				fail_count++;
			end
			if (start && busy === 1'b0)
				expected_clips.insert(expected_clips.size(), clip_segment(seg_start_x,
					seg_start_y, seg_end_x, seg_end_y, point_x, point_y));
		end
		pending = expected_clips.size();
	end

endmodule

[tb/segment_clip_by_point_dominance_tb.sv]
// Testbench top for the segment clipper: drives transactions and gives the verdict.
`timescale 1ns / 1ps
module segment_clip_by_point_dominance_tb;

	typedef logic signed [scpd_pkg::COORD_WIDTH-1:0] coord_t;

	localparam coord_t MAXC = {1'b0, {(scpd_pkg::COORD_WIDTH-1){1'b1}}};
	localparam coord_t MINC = {1'b1, {(scpd_pkg::COORD_WIDTH-1){1'b0}}};
	localparam int ONE = 1 << 16;
	localparam int LATENCY = scpd_pkg::COORD_WIDTH + 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, divide_fault;
	coord_t seg_start_x = '0, seg_start_y = '0, seg_end_x = '0, seg_end_y = '0;
	coord_t point_x = '0, point_y = '0;
	logic [1:0] fragment_count;
	coord_t first_x0, first_y0, first_x1, first_y1;
	coord_t second_x0, second_y0, second_x1, second_y1;
	int fail_count, pending;

	always #5 clk = ~clk;

	segment_clip_by_point_dominance dut (.*);
	segment_clip_by_point_dominance_chk chk (.*);

	task automatic send_clip(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			coord_t px, coord_t py);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		seg_start_x <= sx; seg_start_y <= sy; seg_end_x <= ex; seg_end_y <= ey;
		point_x <= px; point_y <= py;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 200)) - 100) * ONE;
			default: return coord_t'($signed($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	initial begin
		int mode, i;
		coord_t sx, sy, ex, ey;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Descending and rising segments against points in each region.
		send_clip(0, 10*ONE, 10*ONE, 0, 5*ONE, 5*ONE);
		send_clip(0, 10*ONE, 10*ONE, 0, 2*ONE, 2*ONE);
		send_clip(0, 10*ONE, 10*ONE, 0, 8*ONE, 8*ONE);
		send_clip(0, 10*ONE, 10*ONE, 0, -ONE, -ONE);
		send_clip(0, 10*ONE, 10*ONE, 0, -ONE, 4*ONE);
		send_clip(0, 10*ONE, 10*ONE, 0, 4*ONE, -ONE);
		send_clip(10*ONE, 0, 0, 10*ONE, 20*ONE, 20*ONE);
		send_clip(10*ONE, 0, 0, 10*ONE, 12*ONE, ONE);
		send_clip(0, 0, 10*ONE, 10*ONE, 5*ONE, 2*ONE);
		send_clip(0, 0, 10*ONE, 10*ONE, 2*ONE, 5*ONE);
		send_clip(10*ONE, 10*ONE, 0, 0, 20*ONE, ONE);
		send_clip(0, 0, 10*ONE, 10*ONE, -ONE, -ONE);
		send_clip(0, 0, 10*ONE, 10*ONE, 5*ONE, 5*ONE);
		// Zero divisors: vertical and horizontal segments.
		send_clip(ONE, 0, ONE, 10*ONE, 0, 0);
		send_clip(0, ONE, 10*ONE, ONE, 0, 0);
		send_clip(MAXC, MAXC, MAXC, MAXC, MINC, MINC);
		// Extremes that drive the interpolation into saturation.
		send_clip(MINC, MAXC, MAXC, MINC, 0, 0);
		send_clip(MINC, MINC, MAXC, MAXC, MINC, MAXC);
		send_clip(MINC, MAXC, MINC + 1, MINC, MAXC, MAXC);
		send_clip(MAXC, MINC, MAXC - 1, MAXC, MINC, MINC);
		send_clip(-1, -1, 0, 0, MAXC, MINC);
		send_clip(MINC, 0, MAXC, 1, MAXC, MAXC);
		for (i = 0; i < 450; i++) begin
			mode = $urandom_range(0, 2);
			sx = rand_coord(mode); sy = rand_coord(mode);
			ex = rand_coord(mode); ey = rand_coord(mode);
			if ($urandom_range(0, 19) == 0) ex = sx;
			send_clip(sx, sy, ex, ey, rand_coord(mode), rand_coord(mode));
		end
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
